// ===== rtl/pttlb_pkg.sv =====
`default_nettype none

package pttlb_pkg;

  localparam int unsigned ACT_W      = 2;
  localparam int unsigned VA_W       = 32;
  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned IDX_IN_W   = 6;
  localparam int unsigned VPAGE_W    = 25;
  localparam int unsigned PPAGE_W    = 16;
  localparam int unsigned FC_W       = 3;
  localparam int unsigned PA_W       = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [ACT_W-1:0] ACT_TRANSLATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ      = 2'd2;

  localparam logic [FC_W-1:0] FC_NONE      = 3'd0;
  localparam logic [FC_W-1:0] FC_ADDR_ERR  = 3'd1;
  localparam logic [FC_W-1:0] FC_PAGE_FLT  = 3'd2;
  localparam logic [FC_W-1:0] FC_READ_ONLY = 3'd3;
  localparam logic [FC_W-1:0] FC_BUS_ERR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_TLB = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PT_SIZE = 1'd1;

  localparam logic [SIZE_W-1:0] LEGAL_SIZE = 4'd1;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [VA_W-1:0]     virt_addr;
    logic [SIZE_W-1:0]   access_size;
    logic                is_write;
    logic [IDX_IN_W-1:0] entry_index;
    logic [VPAGE_W-1:0]  new_virtual_page;
    logic [PPAGE_W-1:0]  new_physical_page;
    logic                new_valid;
    logic                new_read_only;
    logic                new_used;
    logic                new_dirty;
  } in_item_t;

  typedef struct packed {
    logic [FC_W-1:0]    fault_code;
    logic [PA_W-1:0]    phys_addr;
    logic [VPAGE_W-1:0] read_virtual_page;
    logic [PPAGE_W-1:0] read_physical_page;
    logic               read_valid;
    logic               read_read_only;
    logic               read_used;
    logic               read_dirty;
  } out_item_t;

  typedef struct packed {
    logic [VPAGE_W-1:0] vpage;
    logic [PPAGE_W-1:0] ppage;
    logic               valid;
    logic               read_only;
    logic               used;
    logic               dirty;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/page_table_tlb_translate.sv =====
// address translator with a translation store of TABLE_DEPTH entries
//
// in channel: in_valid_i/in_ready_o carry one beat per action (translate,
// write entry, read entry back). out channel: out_valid_o/out_ready_i carry
// exactly one result beat for every input beat, in order.
// cfg channel: cfg_valid_i/cfg_ready_o write use_tlb_mode (index 0) or
// page_table_size (index 1); cfg_ready_o is always high, write only when idle.
//
// each accepted beat reads the store into its read register; the finish step
// then runs the fault checks, writes a fault-free translation's use/dirty update
// into the store and loads the output register that drives out_valid_o. no new beat is
// accepted until the previous one has finished.
// tlb mode matches against a register copy of the first TLB_ENTRIES tags (at most TABLE_DEPTH).
// PAGE_SIZE must be a power of two.
//
// reset: config registers clear, then a clearing pass zeroes every store entry
// while in_ready_o stays low.
// stall: a finished result sits in the output register; the next item is
// accepted, but its result waits until out_ready_i takes the earlier one.
`default_nettype none

module page_table_tlb_translate #(
  parameter int unsigned PAGE_SIZE      = 128,
  parameter int unsigned TLB_ENTRIES    = 4,
  parameter int unsigned TABLE_DEPTH    = 64,
  parameter int unsigned NUM_PHYS_PAGES = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire pttlb_pkg::in_item_t                 in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output pttlb_pkg::out_item_t                     out_item_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pttlb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pttlb_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  pttlb_pkg::ctrl_cmd_t cmd;
  pttlb_pkg::ctrl_sts_t sts;

  pttlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pttlb_dp #(
    .PAGE_SIZE      (PAGE_SIZE),
    .TLB_ENTRIES    (TLB_ENTRIES),
    .TABLE_DEPTH    (TABLE_DEPTH),
    .NUM_PHYS_PAGES (NUM_PHYS_PAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // a beat keeps the block busy: in_ready_o goes low after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // a result is only loaded into a free output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  // output valid only comes up from a finish step
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("result without a finished item");

endmodule

`default_nettype wire

// ===== rtl/pttlb_ram.sv =====
`default_nettype none

module pttlb_ram #(
  parameter int unsigned WIDTH = 45,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pttlb_ctrl.sv =====
`default_nettype none

module pttlb_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire pttlb_pkg::ctrl_sts_t  sts_i,
  output pttlb_pkg::ctrl_cmd_t       cmd_o
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the store read data until the output slot frees up
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pttlb_dp.sv =====
`default_nettype none

module pttlb_dp #(
  parameter int unsigned PAGE_SIZE      = 128,
  parameter int unsigned TLB_ENTRIES    = 4,
  parameter int unsigned TABLE_DEPTH    = 64,
  parameter int unsigned NUM_PHYS_PAGES = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire pttlb_pkg::ctrl_cmd_t                    cmd_i,
  output pttlb_pkg::ctrl_sts_t                         sts_o,
  input  wire pttlb_pkg::in_item_t                     in_item_i,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [pttlb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [pttlb_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output pttlb_pkg::out_item_t                         out_item_o
);

  localparam int unsigned OFF_W = $clog2(PAGE_SIZE);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned TLB_N = (TLB_ENTRIES < TABLE_DEPTH) ? TLB_ENTRIES : TABLE_DEPTH;
  localparam int unsigned ENT_W = $bits(pttlb_pkg::entry_t);
  localparam int unsigned PW_W  = pttlb_pkg::PPAGE_W + OFF_W;

  // configuration
  logic                                use_tlb_q;
  logic [pttlb_pkg::CFG_DATA_W-1:0]    pt_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_tlb_q <= 1'b0;
      pt_size_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pttlb_pkg::CFG_USE_TLB: use_tlb_q <= cfg_data_i[0];
        pttlb_pkg::CFG_PT_SIZE: pt_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clearing pass counter
  logic [IDX_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + IDX_W'(1);
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == IDX_W'(TABLE_DEPTH - 1));

  // decode of the incoming item
  logic [31:0]      vpn;
  logic [31:0]      idx32;
  logic             idx_ok;
  logic             size_ok;
  logic             lin_err;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [pttlb_pkg::FC_W-1:0] pre_fc;

  // copy of the searchable entries' tags
  logic [pttlb_pkg::VPAGE_W-1:0] sh_vpage_q [TLB_N];
  logic [TLB_N-1:0]              sh_valid_q;

  assign vpn     = in_item_i.virt_addr >> OFF_W;
  assign idx32   = 32'(in_item_i.entry_index);
  assign idx_ok  = idx32 < 32'(TABLE_DEPTH);
  assign size_ok = in_item_i.access_size == pttlb_pkg::LEGAL_SIZE;
  assign lin_err = (vpn >= 32'(pt_size_q)) || (vpn >= 32'(TABLE_DEPTH));

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    // lowest matching entry wins
    for (int i = TLB_N - 1; i >= 0; i--) begin
      if (sh_valid_q[i] && (32'(sh_vpage_q[i]) == vpn)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    pre_fc  = pttlb_pkg::FC_NONE;
    rd_addr = idx32[IDX_W-1:0];
    if (in_item_i.action == pttlb_pkg::ACT_TRANSLATE) begin
      if (use_tlb_q) begin
        rd_addr = hit_idx;
      end else begin
        rd_addr = vpn[IDX_W-1:0];
      end
      if (!size_ok) begin
        pre_fc = pttlb_pkg::FC_ADDR_ERR;
      end else if (!use_tlb_q && lin_err) begin
        pre_fc = pttlb_pkg::FC_ADDR_ERR;
      end else if (use_tlb_q && !hit) begin
        pre_fc = pttlb_pkg::FC_PAGE_FLT;
      end
    end
  end

  logic acc_wr;
  assign acc_wr = cmd_i.accept && (in_item_i.action == pttlb_pkg::ACT_WRITE) && idx_ok;

  pttlb_pkg::entry_t new_entry;
  assign new_entry.vpage     = in_item_i.new_virtual_page;
  assign new_entry.ppage     = in_item_i.new_physical_page;
  assign new_entry.valid     = in_item_i.new_valid;
  assign new_entry.read_only = in_item_i.new_read_only;
  assign new_entry.used      = in_item_i.new_used;
  assign new_entry.dirty     = in_item_i.new_dirty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_valid_q <= '0;
    end else if (acc_wr) begin
      for (int i = 0; i < TLB_N; i++) begin
        if (idx32 == 32'(i)) begin
          sh_valid_q[i] <= in_item_i.new_valid;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_wr) begin
      for (int i = 0; i < TLB_N; i++) begin
        if (idx32 == 32'(i)) begin
          sh_vpage_q[i] <= in_item_i.new_virtual_page;
        end
      end
    end
  end

  // item held for the finish step
  logic [pttlb_pkg::ACT_W-1:0] act_q;
  logic                        wr_q;
  logic [OFF_W-1:0]            off_q;
  logic [pttlb_pkg::FC_W-1:0]  pre_fc_q;
  logic [IDX_W-1:0]            addr_q;
  logic                        idx_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q    <= in_item_i.action;
      wr_q     <= in_item_i.is_write;
      off_q    <= in_item_i.virt_addr[OFF_W-1:0];
      pre_fc_q <= pre_fc;
      addr_q   <= rd_addr;
      idx_ok_q <= idx_ok;
    end
  end

  // store
  pttlb_pkg::entry_t  rd_entry;
  pttlb_pkg::entry_t  wb_entry;
  logic [ENT_W-1:0]   ram_rdata;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic               wb_we;

  assign rd_entry = pttlb_pkg::entry_t'(ram_rdata);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = wb_entry;
    if (cmd_i.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (acc_wr) begin
      ram_we    = 1'b1;
      ram_waddr = idx32[IDX_W-1:0];
      ram_wdata = new_entry;
    end else if (wb_we) begin
      ram_we = 1'b1;
    end
  end

  pttlb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // finish step: fault checks, address, read-back fields, use/dirty update
  pttlb_pkg::out_item_t out_d;
  logic [PW_W-1:0]      pa_wide;

  assign pa_wide = {rd_entry.ppage, off_q};

  always_comb begin
    out_d    = '0;
    wb_we    = 1'b0;
    wb_entry = rd_entry;
    wb_entry.used  = 1'b1;
    wb_entry.dirty = rd_entry.dirty | wr_q;
    case (act_q)
      pttlb_pkg::ACT_TRANSLATE: begin
        if (pre_fc_q != pttlb_pkg::FC_NONE) begin
          out_d.fault_code = pre_fc_q;
        end else if (!rd_entry.valid) begin
          out_d.fault_code = pttlb_pkg::FC_PAGE_FLT;
        end else if (rd_entry.read_only && wr_q) begin
          out_d.fault_code = pttlb_pkg::FC_READ_ONLY;
        end else if (32'(rd_entry.ppage) >= 32'(NUM_PHYS_PAGES)) begin
          out_d.fault_code = pttlb_pkg::FC_BUS_ERR;
        end else begin
          out_d.phys_addr = pa_wide[pttlb_pkg::PA_W-1:0];
          wb_we           = cmd_i.finish;
        end
      end
      pttlb_pkg::ACT_READ: begin
        if (idx_ok_q) begin
          out_d.read_virtual_page  = rd_entry.vpage;
          out_d.read_physical_page = rd_entry.ppage;
          out_d.read_valid         = rd_entry.valid;
          out_d.read_read_only     = rd_entry.read_only;
          out_d.read_used          = rd_entry.used;
          out_d.read_dirty         = rd_entry.dirty;
        end
      end
      default: ;
    endcase
  end

  // output register
  logic                 out_valid_q;
  pttlb_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule

`default_nettype wire
